>>> hdl/ttg_pkg.sv
`default_nettype none

package ttg_pkg;

  localparam int TempW    = 10;
  localparam int BandW    = 20;
  localparam int CfgByteW = 8;
  localparam int CapW     = 21;
  localparam int CapsW    = 63;
  localparam int TimeW    = 32;
  localparam int TotW     = 40;
  localparam int LevelW   = 2;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 63;

  localparam int PersistBitsDef = 8;
  localparam int CapBitsDef     = 21;

  localparam logic [TempW-1:0]    ShutdownTempRst   = 10'd1023;
  localparam logic [CfgByteW-1:0] PersistLimitRst   = 8'd30;
  localparam logic [CfgByteW-1:0] PersistCeilingRst = 8'd60;

  localparam logic [LevelW-1:0] LvlNone = 2'd0;
  localparam logic [LevelW-1:0] LvlLow  = 2'd1;
  localparam logic [LevelW-1:0] LvlMid  = 2'd2;
  localparam logic [LevelW-1:0] LvlMax  = 2'd3;

  typedef enum logic [CfgIdxW-1:0] {
    RegShutdownTemp   = 3'd0,
    RegLowBand        = 3'd1,
    RegMidBand        = 3'd2,
    RegMaxBand        = 3'd3,
    RegPersistLimit   = 3'd4,
    RegPersistCeiling = 3'd5,
    RegBandCaps       = 3'd6,
    RegFallbackCap    = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [TempW-1:0] temp_sample;
    logic             read_ok;
    logic             policy_present;
    logic [CapW-1:0]  current_cap;
    logic [TimeW-1:0] now_ms;
  } in_word_t;

  typedef struct packed {
    logic [LevelW-1:0] level;
    logic              cap_update;
    logic [CapW-1:0]   new_cap;
    logic              fallback_used;
    logic              shutdown_request;
    logic              read_error;
    logic [TotW-1:0]   low_time_ms;
    logic [TotW-1:0]   mid_time_ms;
    logic [TotW-1:0]   max_time_ms;
  } out_word_t;

endpackage

`default_nettype wire

>>> hdl/thermal_throttle_governor_top.sv
`default_nettype none

// Thermal throttle governor: one temperature sample per word in, one status word out.
// A word is taken every cycle while the output register is empty or being drained; its
// result appears in the output register on the next cycle. The whole update (three
// persistence counters, the level decision, cap selection and one 40-bit saturating
// residency add) is all combinational. Configuration writes are always ready and
// take effect on the next accepted word.
module thermal_throttle_governor_top #(
  parameter int PERSIST_BITS = ttg_pkg::PersistBitsDef,
  parameter int CAP_BITS     = ttg_pkg::CapBitsDef
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire  [ttg_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  wire  [ttg_pkg::CfgDataW-1:0]    cfg_data_i,
  input  wire                             in_valid_i,
  output logic                            in_stall_o,
  input  wire  ttg_pkg::in_word_t         in_word_i,
  output logic                            out_valid_o,
  input  wire                             out_stall_i,
  output ttg_pkg::out_word_t              out_word_o
);
  import ttg_pkg::*;

  localparam int SavedW = (CAP_BITS < CapW) ? CAP_BITS : CapW;
  localparam int CmpW   = (PERSIST_BITS > CfgByteW) ? PERSIST_BITS : CfgByteW;

  // configuration
  logic [TempW-1:0]    shutdown_temp_q;
  logic [BandW-1:0]    low_band_q, mid_band_q, max_band_q;
  logic [CfgByteW-1:0] persist_limit_q, persist_ceiling_q;
  logic [CapsW-1:0]    band_caps_q;
  logic [CapW-1:0]     fallback_cap_q;

  // governor state
  logic [PERSIST_BITS-1:0] low_persist_q, low_persist_d;
  logic [PERSIST_BITS-1:0] mid_persist_q, mid_persist_d;
  logic [PERSIST_BITS-1:0] max_persist_q, max_persist_d;
  logic [LevelW-1:0]       level_q, level_d;
  logic [SavedW-1:0]       saved_cap_q, saved_cap_d;
  logic [TimeW-1:0]        start_ms_q, start_ms_d;
  logic                    start_valid_q, start_valid_d;
  logic [TotW-1:0]         times_q [3];
  logic [TotW-1:0]         times_d [3];

  logic      out_valid_q;
  out_word_t out_word_q, out_word_d;
  logic      accept;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign accept      = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  function automatic logic [PERSIST_BITS-1:0] move_cnt(
    input logic [PERSIST_BITS-1:0] cnt,
    input logic [TempW-1:0]        temp,
    input logic [BandW-1:0]        band,
    input logic [CfgByteW-1:0]     ceiling
  );
    logic [PERSIST_BITS-1:0] res;
    res = cnt;
    if (temp > band[TempW-1:0]) begin
      if ((CmpW'(cnt) < CmpW'(ceiling)) && (cnt != '1)) begin
        res = cnt + 1'b1;
      end
    end else if ((temp < band[BandW-1:TempW]) && (cnt != '0)) begin
      res = cnt - 1'b1;
    end
    return res;
  endfunction

  logic [63:0]       caps_ext;
  logic [CapW-1:0]   band_cap [3];
  logic [LevelW-1:0] lvl_forced, lvl_new;
  logic              shut, upd, fb;
  logic [CapW-1:0]   cap;
  logic [TimeW-1:0]  delta;
  logic [TotW-1:0]   tot_sel;
  logic [TotW:0]     tot_sum;
  logic [TotW-1:0]   tot_new;

  always_comb begin
    caps_ext = {1'b0, band_caps_q};
    for (int k = 0; k < 3; k++) begin
      band_cap[k] = CapW'(SavedW'(caps_ext >> (k * CAP_BITS)));
    end
  end

  always_comb begin
    low_persist_d = low_persist_q;
    mid_persist_d = mid_persist_q;
    max_persist_d = max_persist_q;
    level_d       = level_q;
    saved_cap_d   = saved_cap_q;
    start_ms_d    = start_ms_q;
    start_valid_d = start_valid_q;
    for (int k = 0; k < 3; k++) begin
      times_d[k] = times_q[k];
    end
    shut = 1'b0;
    upd  = 1'b0;
    fb   = 1'b0;
    cap  = '0;

    shut       = in_word_i.temp_sample >= shutdown_temp_q;
    lvl_forced = shut ? LvlMax : level_q;

    if (in_word_i.policy_present && (lvl_forced == LvlNone)) begin
      saved_cap_d = SavedW'(in_word_i.current_cap);
    end

    low_persist_d = move_cnt(low_persist_q, in_word_i.temp_sample, low_band_q,
                             persist_ceiling_q);
    mid_persist_d = move_cnt(mid_persist_q, in_word_i.temp_sample, mid_band_q,
                             persist_ceiling_q);
    max_persist_d = move_cnt(max_persist_q, in_word_i.temp_sample, max_band_q,
                             persist_ceiling_q);

    if (CmpW'(max_persist_d) > CmpW'(persist_limit_q)) begin
      lvl_new = LvlMax;
    end else if (CmpW'(mid_persist_d) > CmpW'(persist_limit_q)) begin
      lvl_new = LvlMid;
    end else if (CmpW'(low_persist_d) > CmpW'(persist_limit_q)) begin
      lvl_new = LvlLow;
    end else begin
      lvl_new = LvlNone;
    end

    upd = lvl_new != lvl_forced;
    if (upd) begin
      case (lvl_new)
        LvlNone: begin
          if (saved_cap_d != '0) begin
            cap = CapW'(saved_cap_d);
          end else begin
            cap = fallback_cap_q;
            fb  = 1'b1;
          end
        end
        LvlLow:  cap = band_cap[0];
        LvlMid:  cap = band_cap[1];
        default: cap = band_cap[2];
      endcase
    end
    level_d = lvl_new;

    // close the open residency interval into the level that opened it
    delta = in_word_i.now_ms - start_ms_q;
    case (level_q)
      LvlLow:  tot_sel = times_q[0];
      LvlMid:  tot_sel = times_q[1];
      default: tot_sel = times_q[2];
    endcase
    tot_sum = {1'b0, tot_sel} + (TotW + 1)'(delta);
    tot_new = tot_sum[TotW] ? '1 : tot_sum[TotW-1:0];
    if (start_valid_q) begin
      case (level_q)
        LvlLow:  times_d[0] = tot_new;
        LvlMid:  times_d[1] = tot_new;
        LvlMax:  times_d[2] = tot_new;
        default: ;
      endcase
    end

    start_valid_d = lvl_new != LvlNone;
    start_ms_d    = start_valid_d ? in_word_i.now_ms : '0;

    if (!in_word_i.read_ok) begin
      low_persist_d = low_persist_q;
      mid_persist_d = mid_persist_q;
      max_persist_d = max_persist_q;
      level_d       = level_q;
      saved_cap_d   = saved_cap_q;
      start_ms_d    = start_ms_q;
      start_valid_d = start_valid_q;
      for (int k = 0; k < 3; k++) begin
        times_d[k] = times_q[k];
      end
      shut = 1'b0;
      upd  = 1'b0;
      fb   = 1'b0;
      cap  = '0;
    end

    out_word_d.level            = level_d;
    out_word_d.cap_update       = upd;
    out_word_d.new_cap          = cap;
    out_word_d.fallback_used    = fb;
    out_word_d.shutdown_request = shut;
    out_word_d.read_error       = ~in_word_i.read_ok;
    out_word_d.low_time_ms      = times_d[0];
    out_word_d.mid_time_ms      = times_d[1];
    out_word_d.max_time_ms      = times_d[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shutdown_temp_q   <= ShutdownTempRst;
      low_band_q        <= '0;
      mid_band_q        <= '0;
      max_band_q        <= '0;
      persist_limit_q   <= PersistLimitRst;
      persist_ceiling_q <= PersistCeilingRst;
      band_caps_q       <= '0;
      fallback_cap_q    <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        RegShutdownTemp:   shutdown_temp_q   <= cfg_data_i[TempW-1:0];
        RegLowBand:        low_band_q        <= cfg_data_i[BandW-1:0];
        RegMidBand:        mid_band_q        <= cfg_data_i[BandW-1:0];
        RegMaxBand:        max_band_q        <= cfg_data_i[BandW-1:0];
        RegPersistLimit:   persist_limit_q   <= cfg_data_i[CfgByteW-1:0];
        RegPersistCeiling: persist_ceiling_q <= cfg_data_i[CfgByteW-1:0];
        RegBandCaps:       band_caps_q       <= cfg_data_i[CapsW-1:0];
        RegFallbackCap:    fallback_cap_q    <= cfg_data_i[CapW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_persist_q <= '0;
      mid_persist_q <= '0;
      max_persist_q <= '0;
      level_q       <= LvlNone;
      saved_cap_q   <= '0;
      start_ms_q    <= '0;
      start_valid_q <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        times_q[k] <= '0;
      end
    end else if (accept) begin
      low_persist_q <= low_persist_d;
      mid_persist_q <= mid_persist_d;
      max_persist_q <= max_persist_d;
      level_q       <= level_d;
      saved_cap_q   <= saved_cap_d;
      start_ms_q    <= start_ms_d;
      start_valid_q <= start_valid_d;
      for (int k = 0; k < 3; k++) begin
        times_q[k] <= times_d[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_word_q <= out_word_d;
    end
  end

`ifndef SYNTHESIS
  // an interval is open exactly while throttled
  a_start_tracks_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_valid_q == (level_q != LvlNone))
    else $error("residency start flag out of step with level");

  a_bad_read_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !in_word_i.read_ok) |=> ($stable(level_q) && $stable(saved_cap_q)
                                        && $stable(low_persist_q)))
    else $error("failed read changed governor state");

  a_fallback_on_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_word_q.fallback_used) |->
      (out_word_q.cap_update && (out_word_q.level == LvlNone)))
    else $error("fallback cap flagged outside a release");

  a_error_word_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_word_q.read_error) |->
      (!out_word_q.cap_update && !out_word_q.shutdown_request
       && (out_word_q.level == level_q)))
    else $error("error word carries an action");
`endif

endmodule

`default_nettype wire
